// ----- design/dtc_pkg.sv -----
// ----------------------------------------------------------------------------
// dtc_pkg
// Shared constants and types of the DMA transfer chunker.
// ----------------------------------------------------------------------------
package dtc_pkg;

    localparam int ADDR_WIDTH_DEF = 32;

    localparam int CHUNK_W = 27;
    localparam int COUNT_W = 31;
    localparam int WIN_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CHUNK_W-1:0] CHUNK_MIN = 27'h1000000;
    localparam logic [CHUNK_W-1:0] CHUNK_MAX = 27'h4000000;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 31'h40000000;
    localparam logic [29:0]        PAGE_BASE_HI = 30'h0;
    localparam logic [1:0]         PAGE_BASE_SEL = 2'b01;

    localparam logic [CHUNK_W-1:0] MAX_CHUNK_RST    = 27'd67108800;
    localparam logic [WIN_W-1:0]   LOCAL_END_RST    = 32'h3FFF_FFFF;
    localparam logic [WIN_W-1:0]   REMOTE_START_RST = 32'h4000_0000;
    localparam logic [WIN_W-1:0]   REMOTE_END_RST   = 32'h7FFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_END    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_START = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_END   = 2'd3;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [WIN_W-1:0] local_end;
        logic [WIN_W-1:0] remote_start;
        logic [WIN_W-1:0] remote_end;
    } t_win;

endpackage

// ----- design/dtc_win_unit.sv -----
// ----------------------------------------------------------------------------
// dtc_win_unit
// Shared window check and address advance for one address per cycle.
// ----------------------------------------------------------------------------
module dtc_win_unit
    import dtc_pkg::*;
#(
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
    input  logic [ADDR_WIDTH-1:0] i_addr,
    input  logic [CHUNK_W-1:0]    i_len,
    input  t_win                  i_win,
    output logic [ADDR_WIDTH-1:0] o_next_addr,
    output logic                  o_ok
);

    logic [ADDR_WIDTH:0] w_addr;
    logic [ADDR_WIDTH:0] w_sum;
    logic [ADDR_WIDTH:0] w_last;
    logic [ADDR_WIDTH:0] w_le;
    logic [ADDR_WIDTH:0] w_rs;
    logic [ADDR_WIDTH:0] w_re;
    logic                w_in_local;
    logic                w_in_remote;

    assign w_addr = (ADDR_WIDTH+1)'(i_addr);
    assign w_le   = (ADDR_WIDTH+1)'(i_win.local_end);
    assign w_rs   = (ADDR_WIDTH+1)'(i_win.remote_start);
    assign w_re   = (ADDR_WIDTH+1)'(i_win.remote_end);

    assign w_sum  = w_addr + (ADDR_WIDTH+1)'(i_len);
    assign w_last = w_sum - (ADDR_WIDTH+1)'(1);

    // local window: the start address is a strict compare against the local end
    assign w_in_local  = (w_addr < w_le) && (w_last <= w_le);
    assign w_in_remote = (w_addr >= w_rs) && (w_last <= w_re);

    assign o_ok        = w_in_local || w_in_remote;
    assign o_next_addr = w_sum[ADDR_WIDTH-1:0];

endmodule

// ----- design/dma_transfer_chunker_unit.sv -----
// ----------------------------------------------------------------------------
// dma_transfer_chunker_unit
// Splits one DMA transfer request into window-checked chunks.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  req     | in        | i_req_valid / o_req_ready   | remote/local address, count, dir
//  rsp     | out       | o_rsp_valid / i_rsp_ready   | page, src, dst, bytes, status,
//          |           |                             | total, last
//  cfg     | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
//  A zero-count request gives its result in the cycle after acceptance.
//  Each chunk passes through ST_SIZE, ST_CHK_SRC and ST_CHK_DST, then waits in
//  ST_OUT until its result is accepted; the order is set by the single
//  window-check adder, used once for source and once for destination.
//  Reset is synchronous; state and config registers return to their reset values, datapath registers are not reset.
//  A stalled result holds the sequencer; no new request is taken until the
//  last result of the current one is accepted.
// ----------------------------------------------------------------------------
module dma_transfer_chunker_unit
    import dtc_pkg::*;
#(
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  logic [31:0]          i_remote_address,
    input  logic [31:0]          i_local_address,
    input  logic [COUNT_W-1:0]   i_byte_count,
    input  logic                 i_to_remote,

    output logic                 o_rsp_valid,
    input  logic                 i_rsp_ready,
    output logic [1:0]           o_page,
    output logic [31:0]          o_src_address,
    output logic [31:0]          o_dst_address,
    output logic [CHUNK_W-1:0]   o_chunk_bytes,
    output logic                 o_status,
    output logic [COUNT_W-1:0]   o_total_bytes,
    output logic                 o_last,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WIN_W-1:0]     i_cfg_data
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SIZE    = 3'd1;
    localparam logic [2:0] ST_CHK_SRC = 3'd2;
    localparam logic [2:0] ST_CHK_DST = 3'd3;
    localparam logic [2:0] ST_OUT     = 3'd4;

    logic [2:0]            r_state;
    logic [2:0]            n_state;

    logic [CHUNK_W-1:0]    r_max_chunk;
    t_win                  r_win;

    logic [ADDR_WIDTH-1:0] r_src;
    logic [ADDR_WIDTH-1:0] r_dst;
    logic [ADDR_WIDTH-1:0] r_src_next;
    logic                  r_src_ok;
    logic [COUNT_W-1:0]    r_left;
    logic [COUNT_W-1:0]    r_total;
    logic [CHUNK_W-1:0]    r_lim;
    logic [CHUNK_W-1:0]    r_len;
    logic [1:0]            r_page;

    logic [1:0]            r_o_page;
    logic [31:0]           r_o_src;
    logic [31:0]           r_o_dst;
    logic [CHUNK_W-1:0]    r_o_bytes;
    logic                  r_o_status;
    logic [COUNT_W-1:0]    r_o_total;
    logic                  r_o_last;

    logic                  w_req_fire;
    logic                  w_rsp_fire;
    logic [31:0]           w_roff;
    logic [COUNT_W-1:0]    w_count;
    logic [CHUNK_W-1:0]    w_lim;
    logic [CHUNK_W-1:0]    w_len;
    logic [ADDR_WIDTH-1:0] w_unit_addr;
    logic [ADDR_WIDTH-1:0] w_unit_next;
    logic                  w_unit_ok;
    logic [COUNT_W-1:0]    w_total_next;

    assign w_req_fire = i_req_valid && o_req_ready;
    assign w_rsp_fire = o_rsp_valid && i_rsp_ready;

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = (r_state == ST_OUT);
    assign o_cfg_ready = 1'b1;

    assign w_roff  = {PAGE_BASE_SEL, i_remote_address[29:0]};
    assign w_count = (i_byte_count > COUNT_MAX) ? COUNT_MAX : i_byte_count;
    assign w_lim   = (r_max_chunk < CHUNK_MIN) ? CHUNK_MIN :
                     (r_max_chunk > CHUNK_MAX) ? CHUNK_MAX : r_max_chunk;
    assign w_len   = (r_left > COUNT_W'(r_lim)) ? r_lim : r_left[CHUNK_W-1:0];

    assign w_unit_addr  = (r_state == ST_CHK_DST) ? r_dst : r_src;
    assign w_total_next = r_total + COUNT_W'(r_len);

    dtc_win_unit #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_win (
        .i_addr      (w_unit_addr),
        .i_len       (r_len),
        .i_win       (r_win),
        .o_next_addr (w_unit_next),
        .o_ok        (w_unit_ok)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_req_fire) begin
                    n_state = (w_count == '0) ? ST_OUT : ST_SIZE;
                end
            end
            ST_SIZE:    n_state = ST_CHK_SRC;
            ST_CHK_SRC: n_state = ST_CHK_DST;
            ST_CHK_DST: n_state = ST_OUT;
            ST_OUT: begin
                if (w_rsp_fire) begin
                    n_state = r_o_last ? ST_IDLE : ST_SIZE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_IDLE;
            r_max_chunk       <= MAX_CHUNK_RST;
            r_win.local_end   <= LOCAL_END_RST;
            r_win.remote_start <= REMOTE_START_RST;
            r_win.remote_end  <= REMOTE_END_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAX_CHUNK:    r_max_chunk        <= i_cfg_data[CHUNK_W-1:0];
                    CFG_LOCAL_END:    r_win.local_end    <= i_cfg_data;
                    CFG_REMOTE_START: r_win.remote_start <= i_cfg_data;
                    CFG_REMOTE_END:   r_win.remote_end   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_req_fire) begin
                    r_src   <= i_to_remote ? ADDR_WIDTH'(i_local_address) : ADDR_WIDTH'(w_roff);
                    r_dst   <= i_to_remote ? ADDR_WIDTH'(w_roff) : ADDR_WIDTH'(i_local_address);
                    r_left  <= w_count;
                    r_total <= '0;
                    r_lim   <= w_lim;
                    r_page  <= i_remote_address[31:30];
                    // empty request result
                    r_o_page   <= i_remote_address[31:30];
                    r_o_src    <= i_to_remote ? i_local_address : w_roff;
                    r_o_dst    <= i_to_remote ? w_roff : i_local_address;
                    r_o_bytes  <= '0;
                    r_o_status <= STATUS_OK;
                    r_o_total  <= '0;
                    r_o_last   <= 1'b1;
                end
            end
            ST_SIZE: begin
                r_len  <= w_len;
                r_left <= r_left - COUNT_W'(w_len);
            end
            ST_CHK_SRC: begin
                r_src_ok   <= w_unit_ok;
                r_src_next <= w_unit_next;
            end
            ST_CHK_DST: begin
                r_o_page <= r_page;
                r_o_src  <= r_src[31:0];
                r_o_dst  <= r_dst[31:0];
                if (r_src_ok && w_unit_ok) begin
                    r_o_bytes  <= r_len;
                    r_o_status <= STATUS_OK;
                    r_o_total  <= w_total_next;
                    r_o_last   <= (r_left == '0);
                    r_total    <= w_total_next;
                    r_src      <= r_src_next;
                    r_dst      <= w_unit_next;
                end else begin
                    r_o_bytes  <= '0;
                    r_o_status <= STATUS_ERR;
                    r_o_total  <= r_total;
                    r_o_last   <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_page        = r_o_page;
    assign o_src_address = r_o_src;
    assign o_dst_address = r_o_dst;
    assign o_chunk_bytes = r_o_bytes;
    assign o_status      = r_o_status;
    assign o_total_bytes = r_o_total;
    assign o_last        = r_o_last;

`ifndef SYNTHESIS
    a_err_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_status) |-> (o_last && (o_chunk_bytes == '0)))
        else $error("error result not final or carries bytes");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_ready |-> !o_rsp_valid)
        else $error("request taken while a result is pending");

    a_full_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_status && !o_last) |-> (o_chunk_bytes == r_lim))
        else $error("non-final chunk is not full size");

    a_continue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rsp_fire && !o_last) |=> !o_req_ready)
        else $error("request ended before its last result");
`endif

endmodule
